// ----- sv/obb_pkg.sv -----
// Package for the oriented box overlap test: transaction types, datapath widths,
// CORDIC angle table. Used by every module of the block; no dependencies.
package obb_pkg;

  localparam int CORD_STEPS = 30;
  localparam int CORD_LAT   = CORD_STEPS + 2;  // fold stage + steps + output register
  localparam int CS_W       = 34;              // CORDIC x, y, z
  localparam int PROD_W     = 66;              // side length times sin/cos
  localparam int E_W        = 34;              // half-axis components
  localparam int CRN_W      = 36;              // corners, doubled-center units
  localparam int D_W        = 38;              // corner differences
  localparam int SPLIT      = 17;              // multiplier split point
  localparam int PP_W       = 56;              // partial product width
  localparam int P_W        = 74;              // dot products

  localparam logic [31:0] ATAN_TURN [CORD_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  localparam logic signed [CS_W-1:0]   CORD_X0   = CS_W'(64'sd652032874);
  localparam logic signed [CS_W-1:0]   TURN_QTR  = CS_W'(64'sd1073741824);
  localparam logic signed [CS_W-1:0]   TURN_HALF = CS_W'(64'sd2147483648);
  localparam logic signed [PROD_W-1:0] RND_HALF  = PROD_W'(64'sd536870912);

  typedef struct packed {
    logic signed [31:0] a_center_x;
    logic signed [31:0] a_center_y;
    logic [30:0]        a_width;
    logic [30:0]        a_height;
    logic [15:0]        a_angle;
    logic signed [31:0] b_center_x;
    logic signed [31:0] b_center_y;
    logic [30:0]        b_width;
    logic [30:0]        b_height;
    logic [15:0]        b_angle;
  } obb_in_t;

  typedef struct packed {
    logic overlapping;
    logic degenerate;
  } obb_out_t;

endpackage

// ----- sv/obb_cordic.sv -----
// Pipelined CORDIC: binary angle to signed Q3.30 (34-bit) cosine and sine, one step per stage.
// Depends on obb_pkg.
module obb_cordic (
  input  logic                         clk,
  input  logic [15:0]                  angle,
  output logic signed [obb_pkg::CS_W-1:0] cos_q,
  output logic signed [obb_pkg::CS_W-1:0] sin_q
);
  import obb_pkg::*;

  logic signed [CS_W-1:0] x_r [CORD_STEPS+1];
  logic signed [CS_W-1:0] y_r [CORD_STEPS+1];
  logic signed [CS_W-1:0] z_r [CORD_STEPS+1];
  logic                   neg_r [CORD_STEPS+1];

  logic signed [31:0]     turn;
  logic signed [CS_W-1:0] z_in;
  logic signed [CS_W-1:0] z_nxt;
  logic                   neg_nxt;

  // fold into [-quarter, quarter] turn, negating both results
  always_comb begin
    turn = $signed({angle, 16'h0000});
    z_in = CS_W'(turn);
    if (z_in > TURN_QTR) begin
      z_nxt   = z_in - TURN_HALF;
      neg_nxt = 1'b1;
    end else if (z_in < -TURN_QTR) begin
      z_nxt   = z_in + TURN_HALF;
      neg_nxt = 1'b1;
    end else begin
      z_nxt   = z_in;
      neg_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= CORD_X0;
    y_r[0]   <= '0;
    z_r[0]   <= z_nxt;
    neg_r[0] <= neg_nxt;
  end

  for (genvar i = 0; i < CORD_STEPS; i++) begin : g_step
    localparam logic signed [CS_W-1:0] AT = CS_W'(ATAN_TURN[i]);
    always_ff @(posedge clk) begin
      neg_r[i+1] <= neg_r[i];
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - AT;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + AT;
      end
    end
  end

  always_ff @(posedge clk) begin
    cos_q <= neg_r[CORD_STEPS] ? -x_r[CORD_STEPS] : x_r[CORD_STEPS];
    sin_q <= neg_r[CORD_STEPS] ? -y_r[CORD_STEPS] : y_r[CORD_STEPS];
  end

endmodule

// ----- sv/obb_dot.sv -----
// Three-stage exact 2-D dot product: split partial products, terms, sum.
// Depends on obb_pkg.
module obb_dot (
  input  logic                           clk,
  input  logic signed [obb_pkg::D_W-1:0] dx,
  input  logic signed [obb_pkg::D_W-1:0] dy,
  input  logic signed [obb_pkg::E_W-1:0] ex,
  input  logic signed [obb_pkg::E_W-1:0] ey,
  output logic signed [obb_pkg::P_W-1:0] dot
);
  import obb_pkg::*;

  logic signed [PP_W-1:0] xl_r, xh_r, yl_r, yh_r;
  logic signed [P_W-1:0]  tx_r, ty_r;

  always_ff @(posedge clk) begin
    xl_r <= PP_W'(dx) * PP_W'($signed({1'b0, ex[SPLIT-1:0]}));
    xh_r <= PP_W'(dx) * PP_W'($signed(ex[E_W-1:SPLIT]));
    yl_r <= PP_W'(dy) * PP_W'($signed({1'b0, ey[SPLIT-1:0]}));
    yh_r <= PP_W'(dy) * PP_W'($signed(ey[E_W-1:SPLIT]));
    tx_r <= (P_W'(xh_r) <<< SPLIT) + P_W'(xl_r);
    ty_r <= (P_W'(yh_r) <<< SPLIT) + P_W'(yl_r);
    dot  <= tx_r + ty_r;
  end

endmodule

// ----- sv/oriented_box_overlap_test.sv -----
// Top level of the oriented box overlap test (2-D separating-axis test).
// Depends on obb_pkg, obb_cordic and obb_dot.
//
//   channel  ports                       handshake
//   input    start, busy, in_data        taken when start && !busy
//   result   out_valid, out_data         one-cycle strobe, no backpressure
//
// One transaction enters every cycle; busy is always low.
// out_valid is carried by a valid shift register sized for the input register, the CORDIC chain and the tail stages.
// Results leave in acceptance order. Reset clears only the valid pipeline.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module oriented_box_overlap_test (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  obb_pkg::obb_in_t  in_data,
  output logic              out_valid,
  output obb_pkg::obb_out_t out_data
);
  import obb_pkg::*;

  localparam int TAIL = 10;
  // input register, CORDIC stages, tail stages
  localparam int NV   = CORD_LAT + TAIL + 1;

  typedef struct packed {
    logic               dgn;
    logic signed [31:0] ax, ay, bx, by;
    logic [30:0]        aw, ah, bw, bh;
  } side_t;

  obb_in_t in_r;
  logic    vld_r [NV+1];
  logic    dgn_r [TAIL];
  side_t   side_r [CORD_LAT];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NV; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= start;
      for (int k = 1; k <= NV; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (start) in_r <= in_data;
    side_r[0].dgn <= (in_r.a_width == '0) || (in_r.a_height == '0) ||
                     (in_r.b_width == '0) || (in_r.b_height == '0);
    side_r[0].ax <= in_r.a_center_x;
    side_r[0].ay <= in_r.a_center_y;
    side_r[0].bx <= in_r.b_center_x;
    side_r[0].by <= in_r.b_center_y;
    side_r[0].aw <= in_r.a_width;
    side_r[0].ah <= in_r.a_height;
    side_r[0].bw <= in_r.b_width;
    side_r[0].bh <= in_r.b_height;
    for (int k = 1; k < CORD_LAT; k++) side_r[k] <= side_r[k-1];
    dgn_r[0] <= side_r[CORD_LAT-1].dgn;
    for (int k = 1; k < TAIL; k++) dgn_r[k] <= dgn_r[k-1];
  end

  // sine / cosine per box
  logic signed [CS_W-1:0] cos_w [2];
  logic signed [CS_W-1:0] sin_w [2];

  obb_cordic u_cord_a (.clk(clk), .angle(in_r.a_angle), .cos_q(cos_w[0]), .sin_q(sin_w[0]));
  obb_cordic u_cord_b (.clk(clk), .angle(in_r.b_angle), .cos_q(cos_w[1]), .sin_q(sin_w[1]));

  logic signed [31:0] cx_w [2];
  logic signed [31:0] cy_w [2];
  logic [30:0]        w_w  [2];
  logic [30:0]        h_w  [2];

  assign cx_w[0] = side_r[CORD_LAT-1].ax;
  assign cy_w[0] = side_r[CORD_LAT-1].ay;
  assign w_w[0]  = side_r[CORD_LAT-1].aw;
  assign h_w[0]  = side_r[CORD_LAT-1].ah;
  assign cx_w[1] = side_r[CORD_LAT-1].bx;
  assign cy_w[1] = side_r[CORD_LAT-1].by;
  assign w_w[1]  = side_r[CORD_LAT-1].bw;
  assign h_w[1]  = side_r[CORD_LAT-1].bh;

  logic signed [PROD_W-1:0] pwc_r [2], pws_r [2], phs_r [2], phc_r [2];
  logic signed [31:0]       cx1_r [2], cy1_r [2];
  logic signed [E_W-1:0]    ex_r [2][2];
  logic signed [E_W-1:0]    ey_r [2][2];
  logic signed [CRN_W-1:0]  c2x_r [2], c2y_r [2];
  logic signed [CRN_W-1:0]  px_r [2][4];
  logic signed [CRN_W-1:0]  py_r [2][4];
  logic signed [E_W-1:0]    ex3_r [2][2];
  logic signed [E_W-1:0]    ey3_r [2][2];

  for (genvar b = 0; b < 2; b++) begin : g_box
    always_ff @(posedge clk) begin
      // side times sin/cos
      pwc_r[b] <= PROD_W'($signed({1'b0, w_w[b]})) * PROD_W'(cos_w[b]);
      pws_r[b] <= PROD_W'($signed({1'b0, w_w[b]})) * PROD_W'(sin_w[b]);
      phs_r[b] <= PROD_W'($signed({1'b0, h_w[b]})) * PROD_W'(sin_w[b]);
      phc_r[b] <= PROD_W'($signed({1'b0, h_w[b]})) * PROD_W'(cos_w[b]);
      cx1_r[b] <= cx_w[b];
      cy1_r[b] <= cy_w[b];
      // round to nearest, ties up
      ex_r[b][0] <= E_W'((pwc_r[b] + RND_HALF) >>> 30);
      ey_r[b][0] <= E_W'((pws_r[b] + RND_HALF) >>> 30);
      ex_r[b][1] <= -E_W'((phs_r[b] + RND_HALF) >>> 30);
      ey_r[b][1] <= E_W'((phc_r[b] + RND_HALF) >>> 30);
      c2x_r[b]   <= CRN_W'(cx1_r[b]) <<< 1;
      c2y_r[b]   <= CRN_W'(cy1_r[b]) <<< 1;
      // corners: 2c -+ X -+ Y
      px_r[b][0] <= c2x_r[b] - CRN_W'(ex_r[b][0]) - CRN_W'(ex_r[b][1]);
      py_r[b][0] <= c2y_r[b] - CRN_W'(ey_r[b][0]) - CRN_W'(ey_r[b][1]);
      px_r[b][1] <= c2x_r[b] + CRN_W'(ex_r[b][0]) - CRN_W'(ex_r[b][1]);
      py_r[b][1] <= c2y_r[b] + CRN_W'(ey_r[b][0]) - CRN_W'(ey_r[b][1]);
      px_r[b][2] <= c2x_r[b] + CRN_W'(ex_r[b][0]) + CRN_W'(ex_r[b][1]);
      py_r[b][2] <= c2y_r[b] + CRN_W'(ey_r[b][0]) + CRN_W'(ey_r[b][1]);
      px_r[b][3] <= c2x_r[b] - CRN_W'(ex_r[b][0]) + CRN_W'(ex_r[b][1]);
      py_r[b][3] <= c2y_r[b] - CRN_W'(ey_r[b][0]) + CRN_W'(ey_r[b][1]);
      for (int a = 0; a < 2; a++) begin
        ex3_r[b][a] <= ex_r[b][a];
        ey3_r[b][a] <= ey_r[b][a];
      end
    end
  end

  // projections: group g = direction*2 + axis; j = 0 is the own extent, 1..4 the corners
  logic signed [D_W-1:0] dx_r [4][5];
  logic signed [D_W-1:0] dy_r [4][5];
  logic signed [E_W-1:0] pex_r [4];
  logic signed [E_W-1:0] pey_r [4];
  logic signed [P_W-1:0] dot_w [4][5];

  for (genvar g = 0; g < 4; g++) begin : g_grp
    localparam int P   = g / 2;
    localparam int Q   = 1 - P;
    localparam int AX  = g % 2;
    localparam int FAR = (AX == 1) ? 3 : 1;

    always_ff @(posedge clk) begin
      pex_r[g]   <= ex3_r[P][AX];
      pey_r[g]   <= ey3_r[P][AX];
      dx_r[g][0] <= D_W'(px_r[P][FAR]) - D_W'(px_r[P][0]);
      dy_r[g][0] <= D_W'(py_r[P][FAR]) - D_W'(py_r[P][0]);
      for (int k = 0; k < 4; k++) begin
        dx_r[g][k+1] <= D_W'(px_r[Q][k]) - D_W'(px_r[P][0]);
        dy_r[g][k+1] <= D_W'(py_r[Q][k]) - D_W'(py_r[P][0]);
      end
    end

    for (genvar j = 0; j < 5; j++) begin : g_dot
      obb_dot u_dot (
        .clk(clk), .dx(dx_r[g][j]), .dy(dy_r[g][j]),
        .ex(pex_r[g]), .ey(pey_r[g]), .dot(dot_w[g][j])
      );
    end
  end

  logic signed [P_W-1:0] bnd1_r [4], mn01_r [4], mn23_r [4], mx01_r [4], mx23_r [4];
  logic signed [P_W-1:0] bnd2_r [4], lo_r [4], hi_r [4];
  logic [3:0]            sep_r;

  for (genvar g = 0; g < 4; g++) begin : g_cmp
    always_ff @(posedge clk) begin
      bnd1_r[g] <= dot_w[g][0];
      mn01_r[g] <= (dot_w[g][2] < dot_w[g][1]) ? dot_w[g][2] : dot_w[g][1];
      mx01_r[g] <= (dot_w[g][2] > dot_w[g][1]) ? dot_w[g][2] : dot_w[g][1];
      mn23_r[g] <= (dot_w[g][4] < dot_w[g][3]) ? dot_w[g][4] : dot_w[g][3];
      mx23_r[g] <= (dot_w[g][4] > dot_w[g][3]) ? dot_w[g][4] : dot_w[g][3];
      bnd2_r[g] <= bnd1_r[g];
      lo_r[g]   <= (mn23_r[g] < mn01_r[g]) ? mn23_r[g] : mn01_r[g];
      hi_r[g]   <= (mx23_r[g] > mx01_r[g]) ? mx23_r[g] : mx01_r[g];
      // touching counts as overlap
      sep_r[g]  <= (bnd2_r[g] < lo_r[g]) || (hi_r[g] < 0);
    end
  end

  always_ff @(posedge clk) begin
    out_data.overlapping <= !dgn_r[TAIL-1] && (sep_r == '0);
    out_data.degenerate  <= dgn_r[TAIL-1];
  end

  assign out_valid = vld_r[NV];

endmodule
